// ===== sv/kvat_pkg.sv =====
`default_nettype none

package kvat_pkg;

  // table geometry and field widths
  localparam int ENTRIES   = 16;
  localparam int IDX_W     = 4;
  localparam int HW_W      = 5;
  localparam int KEY_BYTES = 7;
  localparam int VAL_BYTES = 8;
  localparam int KEY_W     = 56;
  localparam int VAL_W     = 64;
  localparam int IN_W      = 128;
  localparam int OUT_W     = 128;

  // command codes
  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_GET   = 2'd1,
    OP_UNSET = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // sequencer states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_LOOK = 1'b1
  } state_t;

  // command broadcast to every slot of the row
  typedef struct packed {
    logic             go;
    op_t              op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] index;
    logic             any_hit;
  } slot_cmd_t;

  // what one slot reports back
  typedef struct packed {
    logic             found;
    logic             claim;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } slot_rsp_t;

  // keep bytes up to the first zero byte, at most nbytes of them
  function automatic logic [63:0] norm_str(input logic [63:0] v, input int nbytes);
    logic [63:0] r;
    logic        stop;
    r    = '0;
    stop = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (i >= nbytes || v[8*i +: 8] == 8'd0) begin
        stop = 1'b1;
      end
      if (!stop) begin
        r[8*i +: 8] = v[8*i +: 8];
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/kvat_cell.sv =====
`default_nettype none

module kvat_cell (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [kvat_pkg::IDX_W-1:0] slot_idx,
  input  wire kvat_pkg::slot_cmd_t        cmd,
  input  wire logic                      hit_in,
  input  wire logic                      free_in,
  output      logic                      hit_out,
  output      logic                      free_out,
  output      kvat_pkg::slot_rsp_t        rsp
);

  logic                        valid_r, valid_nxt;
  logic [kvat_pkg::KEY_W-1:0]  key_r, key_nxt;
  logic [kvat_pkg::VAL_W-1:0]  value_r, value_nxt;
  logic                        hit;
  logic                        first_hit;
  logic                        claim;
  logic                        rd_sel;
  logic                        get_sel;

  // key compare and the priority chain to the next slot
  assign hit       = valid_r && (key_r == cmd.key);
  assign first_hit = hit && !hit_in;
  assign hit_out   = hit_in || hit;
  assign free_out  = free_in || !valid_r;

  // lowest free slot claims on a set that matched nowhere
  assign claim   = (cmd.op == kvat_pkg::OP_SET) && !cmd.any_hit && !valid_r && !free_in;
  assign rd_sel  = (cmd.op == kvat_pkg::OP_READ) && (cmd.index == slot_idx) && valid_r;
  assign get_sel = (cmd.op == kvat_pkg::OP_GET) && first_hit;

  // slot update on commit
  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    value_nxt = value_r;
    if (cmd.go) begin
      case (cmd.op)
        kvat_pkg::OP_SET: begin
          if (first_hit) begin
            value_nxt = cmd.value;
          end else if (claim) begin
            valid_nxt = 1'b1;
            key_nxt   = cmd.key;
            value_nxt = cmd.value;
          end
        end
        kvat_pkg::OP_UNSET: begin
          if (first_hit) begin
            valid_nxt = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
  end

  // masked read data, merged across the row by the top level
  always_comb begin
    rsp.found = get_sel || rd_sel;
    rsp.claim = cmd.go && claim;
    rsp.key   = rd_sel ? key_r : '0;
    rsp.value = (get_sel || rd_sel) ? value_r : '0;
  end

endmodule

`default_nettype wire

// ===== sv/key_value_association_table_top.sv =====
// key/value table as a row of slot cells with a shared key broadcast
// result: the item is captured on accept and its result registered at commit,
//   which is held back while a waiting result item is stalled downstream
// input: a new item is taken only once the last has passed compare-and-commit
//   through the slot row (key compare plus first-hit / first-free chain)
// reset (synchronous, active low) clears every valid mark and the high-water
//   mark at once; no clearing pass, the table takes items the next cycle
`default_nettype none

module key_value_association_table_top (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output      logic                       in_tready,
  // cmd[1:0], key[57:2], value[121:58], index[125:122], zero pad [127:126]
  input  wire logic [kvat_pkg::IN_W-1:0]  in_tdata,
  output      logic                       out_tvalid,
  input  wire logic                       out_tready,
  // status[1:0], out_key[57:2], out_value[121:58], high_water[126:122], zero [127]
  output      logic [kvat_pkg::OUT_W-1:0] out_tdata
);

  kvat_pkg::state_t             state_r, state_nxt;
  kvat_pkg::op_t                op_r;
  logic [kvat_pkg::KEY_W-1:0]   key_r;
  logic [kvat_pkg::VAL_W-1:0]   value_r;
  logic [kvat_pkg::IDX_W-1:0]   index_r;
  logic [kvat_pkg::HW_W-1:0]    hw_r, hw_nxt;
  logic                         out_valid_r;
  logic [kvat_pkg::OUT_W-1:0]   out_data_r, out_data_nxt;
  logic                         in_acc;
  logic                         out_free;
  logic                         go;
  logic [63:0]                  key_norm;
  logic [63:0]                  value_norm;
  kvat_pkg::slot_cmd_t          cmd;
  kvat_pkg::slot_rsp_t          rsp [kvat_pkg::ENTRIES];
  logic [kvat_pkg::ENTRIES:0]   hit_chain;
  logic [kvat_pkg::ENTRIES:0]   free_chain;
  logic                         any_found;
  logic [kvat_pkg::KEY_W-1:0]   rd_key;
  logic [kvat_pkg::VAL_W-1:0]   rd_value;
  kvat_pkg::status_t            status;
  logic [kvat_pkg::KEY_W-1:0]   res_key;
  logic [kvat_pkg::VAL_W-1:0]   res_value;

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign go       = (state_r == kvat_pkg::S_LOOK) && out_free;

  // sequencer: take an item, then commit it when the output slot is free
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    case (state_r)
      kvat_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = kvat_pkg::S_LOOK;
        end
      end
      kvat_pkg::S_LOOK: begin
        if (out_free) begin
          state_nxt = kvat_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = kvat_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kvat_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // input item capture with string normalisation
  assign key_norm   = kvat_pkg::norm_str({8'd0, in_tdata[57:2]}, kvat_pkg::KEY_BYTES);
  assign value_norm = kvat_pkg::norm_str(in_tdata[121:58], kvat_pkg::VAL_BYTES);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r    <= kvat_pkg::op_t'(in_tdata[1:0]);
      key_r   <= key_norm[kvat_pkg::KEY_W-1:0];
      value_r <= value_norm;
      index_r <= in_tdata[125:122];
    end
  end

  // command broadcast to the row
  always_comb begin
    cmd.go      = go;
    cmd.op      = op_r;
    cmd.key     = key_r;
    cmd.value   = value_r;
    cmd.index   = index_r;
    cmd.any_hit = hit_chain[kvat_pkg::ENTRIES];
  end

  assign hit_chain[0]  = 1'b0;
  assign free_chain[0] = 1'b0;

  // row of slot cells, each passing hit and free marks to its neighbour
  for (genvar g = 0; g < kvat_pkg::ENTRIES; g++) begin : g_slot
    kvat_cell u_slot (
      .clk      (clk),
      .rst_n    (rst_n),
      .slot_idx (kvat_pkg::IDX_W'(g)),
      .cmd      (cmd),
      .hit_in   (hit_chain[g]),
      .free_in  (free_chain[g]),
      .hit_out  (hit_chain[g+1]),
      .free_out (free_chain[g+1]),
      .rsp      (rsp[g])
    );
  end

  // merge the row's responses and track the high-water mark
  always_comb begin
    any_found = 1'b0;
    rd_key    = '0;
    rd_value  = '0;
    hw_nxt    = hw_r;
    for (int i = 0; i < kvat_pkg::ENTRIES; i++) begin
      any_found = any_found | rsp[i].found;
      rd_key    = rd_key | rsp[i].key;
      rd_value  = rd_value | rsp[i].value;
      if (rsp[i].claim && (kvat_pkg::HW_W'(i) >= hw_r)) begin
        hw_nxt = kvat_pkg::HW_W'(i + 1);
      end
    end
  end

  // result item
  always_comb begin
    status    = kvat_pkg::ST_OK;
    res_key   = '0;
    res_value = '0;
    case (op_r)
      kvat_pkg::OP_SET: begin
        if (!hit_chain[kvat_pkg::ENTRIES] && !free_chain[kvat_pkg::ENTRIES]) begin
          status = kvat_pkg::ST_FULL;
        end
      end
      kvat_pkg::OP_GET: begin
        if (any_found) begin
          res_value = rd_value;
        end else begin
          status = kvat_pkg::ST_MISS;
        end
      end
      kvat_pkg::OP_UNSET: begin
        if (!hit_chain[kvat_pkg::ENTRIES]) begin
          status = kvat_pkg::ST_MISS;
        end
      end
      kvat_pkg::OP_READ: begin
        if (any_found && ({1'b0, index_r} < hw_r)) begin
          res_key   = rd_key;
          res_value = rd_value;
        end else begin
          status = kvat_pkg::ST_MISS;
        end
      end
      default: begin
        status = kvat_pkg::ST_MISS;
      end
    endcase
    out_data_nxt = {1'b0, hw_nxt, res_value, res_key, status};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hw_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (go) begin
        hw_r        <= hw_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ===== sv/kvat_checker.sv =====
`default_nettype none

module kvat_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_tvalid,
  input wire logic                       in_tready,
  input wire logic                       out_tvalid,
  input wire logic                       out_tready,
  input wire logic [kvat_pkg::OUT_W-1:0] out_tdata
);

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  // one item in work at a time: no accept in the cycle after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while previous item in work");

  // a full table means every slot has been used
  a_full_hw: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == kvat_pkg::ST_FULL |->
      out_tdata[126:122] == kvat_pkg::HW_W'(kvat_pkg::ENTRIES))
    else $error("full status without high-water at table size");

  // status code and high-water mark stay in range
  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != 2'd3 &&
      out_tdata[126:122] <= kvat_pkg::HW_W'(kvat_pkg::ENTRIES))
    else $error("status or high-water out of range");

  // reset empties the output register
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result item valid after reset");

endmodule

bind key_value_association_table_top kvat_checker u_kvat_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import kvat_pkg::*;

  // one result item as seen on the output stream
  typedef struct packed {
    status_t     status;
    logic [55:0] key;
    logic [63:0] value;
    logic [4:0]  hw;
  } kv_result_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;

  // shadow copy of the slot row
  logic        slot_used [16];
  logic [55:0] slot_keys [16];
  logic [63:0] slot_vals [16];
  logic [4:0]  hw_mark;

  kv_result_t  expected_results [$];
  logic [55:0] key_pool [24];
  int          mismatches = 0;
  bit          idle_on = 1'b1;

  key_value_association_table_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // keep bytes up to the first zero byte, at most nbytes of them
  function automatic logic [63:0] clip_string(logic [63:0] raw, int nbytes);
    logic [63:0] res;
    bit          ended;
    res   = '0;
    ended = 1'b0;
    for (int b = 0; b < nbytes; b++) begin
      if (raw[8*b +: 8] == 8'h00) ended = 1'b1;
      if (!ended) res[8*b +: 8] = raw[8*b +: 8];
    end
    return res;
  endfunction

  // first valid slot holding key k, or -1
  function automatic int find_slot(logic [55:0] k);
    for (int i = 0; i < 16; i++) begin
      if (slot_used[i] && slot_keys[i] == k) return i;
    end
    return -1;
  endfunction

  // apply one command to the shadow table and give the item it should produce
  function automatic kv_result_t table_predict(op_t op, logic [55:0] raw_key,
                                               logic [63:0] raw_val, logic [3:0] index);
    kv_result_t  r;
    logic [63:0] k64;
    logic [55:0] k;
    logic [63:0] v;
    int          hit;
    int          free_slot;
    r         = '0;
    r.status  = ST_OK;
    k64       = clip_string({8'h00, raw_key}, 7);
    k         = k64[55:0];
    v         = clip_string(raw_val, 8);
    hit       = find_slot(k);
    free_slot = -1;
    case (op)
      OP_SET: begin
        if (hit >= 0) begin
          slot_vals[hit] = v;
        end else begin
          for (int i = 15; i >= 0; i--) begin
            if (!slot_used[i]) free_slot = i;
          end
          if (free_slot < 0) begin
            r.status = ST_FULL;
          end else begin
            slot_used[free_slot] = 1'b1;
            slot_keys[free_slot] = k;
            slot_vals[free_slot] = v;
            if (free_slot >= hw_mark) hw_mark = 5'(free_slot + 1);
          end
        end
      end
      OP_GET: begin
        if (hit >= 0) r.value = slot_vals[hit];
        else r.status = ST_MISS;
      end
      OP_UNSET: begin
        if (hit >= 0) begin
          slot_used[hit] = 1'b0;
          slot_keys[hit] = '0;
          slot_vals[hit] = '0;
        end else begin
          r.status = ST_MISS;
        end
      end
      default: begin
        if (index < hw_mark && slot_used[index]) begin
          r.key   = slot_keys[index];
          r.value = slot_vals[index];
        end else begin
          r.status = ST_MISS;
        end
      end
    endcase
    r.hw = hw_mark;
    return r;
  endfunction

  function automatic logic [63:0] random_word();
    return {$urandom(), $urandom()};
  endfunction

  // short string of 0..nbytes chars, sometimes with junk past the terminator
  function automatic logic [63:0] make_string(int nbytes);
    logic [63:0] s;
    int          len;
    s   = '0;
    len = $urandom_range(nbytes);
    for (int b = 0; b < len; b++) s[8*b +: 8] = 8'($urandom_range(1, 255));
    if (len < nbytes - 1 && $urandom_range(99) < 25) begin
      for (int b = len + 1; b < nbytes; b++) s[8*b +: 8] = 8'($urandom_range(255));
    end
    return s;
  endfunction

  function automatic logic [55:0] make_key();
    if ($urandom_range(99) < 15) return 56'(random_word());
    return 56'(make_string(7));
  endfunction

  function automatic logic [63:0] make_value();
    if ($urandom_range(99) < 20) return random_word();
    return make_string(8);
  endfunction

  // same key after trimming, but sometimes with junk past the terminator
  function automatic logic [55:0] dress_key(logic [55:0] k);
    logic [55:0] d;
    int          len;
    d   = k;
    len = 0;
    while (len < 7 && k[8*len +: 8] != 8'h00) len++;
    if (len < 6 && $urandom_range(9) < 3) begin
      for (int b = len + 1; b < 7; b++) d[8*b +: 8] = 8'($urandom_range(255));
    end
    return d;
  endfunction

  // offer one item, with a random gap in front of it when idling is on
  task automatic send_item(op_t op, logic [55:0] key, logic [63:0] value,
                           logic [3:0] index);
    int gap;
    gap = 0;
    if (idle_on) begin
      while ($urandom_range(99) < 25) gap++;
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, index, value, key, op};
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(table_predict(op, key, value, index));
  endtask

  // receiver back-pressure
  always @(posedge clk) begin
    out_tready <= !idle_on || ($urandom_range(99) >= 25);
  end

  // compare each result item with the oldest expectation
  always @(posedge clk) begin
    kv_result_t got;
    kv_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = status_t'(out_tdata[1:0]);
      got.key    = out_tdata[57:2];
      got.value  = out_tdata[121:58];
      got.hw     = out_tdata[126:122];
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected item at %0t: status %0d key %h value %h hw %0d",
                   $time, got.status, got.key, got.value, got.hw);
      end else begin
        want = expected_results.pop_front();
        if (got.status != want.status || got.key != want.key ||
            got.value != want.value || got.hw != want.hw) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: expected status %0d key %h value %h hw %0d, %s",
                     $time, want.status, want.key, want.value, want.hw,
                     $sformatf("got status %0d key %h value %h hw %0d",
                               got.status, got.key, got.value, got.hw));
        end
      end
    end
  end

  // lookups on an empty table
  task automatic test_empty_lookups();
    send_item(OP_GET, 56'h6261, 64'h0, 4'd0);
    send_item(OP_READ, 56'h0, 64'h0, 4'd0);
  endtask

  // the all-zero key behaves like any other key
  task automatic test_empty_key();
    send_item(OP_SET, 56'h0, 64'h1122_3344_5566_7788, 4'd0);
    send_item(OP_GET, 56'h0, 64'h0, 4'd0);
    send_item(OP_UNSET, 56'h0, 64'h0, 4'd0);
    send_item(OP_GET, 56'h0, 64'h0, 4'd0);
  endtask

  // junk past the first zero byte is ignored in keys and values
  task automatic test_string_trim();
    send_item(OP_SET, 56'h77_6655_0043_4241, 64'hAABB_0031_3233_3435, 4'hF);
    send_item(OP_GET, 56'h00_0000_0043_4241, 64'hFFFF_FFFF_FFFF_FFFF, 4'h0);
  endtask

  // extreme key and value, then fill every slot and read back the last one
  task automatic test_fill_to_full();
    send_item(OP_SET, '1, '1, 4'hF);
    send_item(OP_SET, '1, 64'h1, 4'h0);
    for (int i = 2; i < 16; i++) begin
      send_item(OP_SET, {40'h0, 8'(8'h30 + i), 8'h6B}, {56'h0, 8'(8'h40 + i)}, 4'(i));
    end
    send_item(OP_SET, 56'h7A_7A7A, 64'h5A, 4'h0);
    send_item(OP_READ, 56'h0, 64'h0, 4'hF);
  endtask

  // alternating fill, drain and mixed phases over a shared pool of keys
  task automatic test_random_traffic(int episodes, int per_episode);
    int          mode;
    int          roll;
    int          j;
    int          set_lim;
    int          get_lim;
    int          unset_lim;
    op_t         op;
    logic [63:0] tmp;
    for (int i = 0; i < 24; i++) begin
      tmp         = clip_string({8'h00, make_key()}, 7);
      key_pool[i] = (i < 16 && slot_used[i]) ? slot_keys[i] : tmp[55:0];
    end
    for (int e = 0; e < episodes; e++) begin
      idle_on = (e >= 6);
      mode    = e % 3;
      // refresh a few pool keys that no slot holds
      repeat (3) begin
        j   = $urandom_range(23);
        tmp = clip_string({8'h00, make_key()}, 7);
        if (find_slot(key_pool[j]) < 0) key_pool[j] = tmp[55:0];
      end
      case (mode)
        0:       begin set_lim = 60; get_lim = 75; unset_lim = 85; end
        1:       begin set_lim = 15; get_lim = 35; unset_lim = 85; end
        default: begin set_lim = 35; get_lim = 60; unset_lim = 85; end
      endcase
      repeat (per_episode) begin
        if ($urandom_range(99) < 8) begin
          send_item(op_t'($urandom_range(3)), 56'(random_word()), random_word(),
                    4'($urandom_range(15)));
        end else begin
          roll = $urandom_range(99);
          if (roll < set_lim) op = OP_SET;
          else if (roll < get_lim) op = OP_GET;
          else if (roll < unset_lim) op = OP_UNSET;
          else op = OP_READ;
          send_item(op, dress_key(key_pool[$urandom_range(23)]), make_value(),
                    4'($urandom_range(15)));
        end
      end
    end
  endtask

  initial begin
    for (int i = 0; i < 16; i++) begin
      slot_used[i] = 1'b0;
      slot_keys[i] = '0;
      slot_vals[i] = '0;
    end
    hw_mark = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_lookups();
    test_empty_key();
    test_string_trim();
    test_fill_to_full();
    test_random_traffic(35, 50);
    in_tvalid <= 1'b0;
    // drain, then leave room for any stray item
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASS key_value_association_table_top");
    end else begin
      $display("FAIL key_value_association_table_top");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("FAIL key_value_association_table_top");
    $finish;
  end

endmodule
